### src/slt_pkg.sv
package slt_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int KW_MAX_LEN_DEF = 6;
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [62:0] VAL_MAX = {63{1'b1}};
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // token kinds
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_BANG    = 6'd12;
  localparam logic [5:0] K_EQUAL   = 6'd14;
  localparam logic [5:0] K_LESS    = 6'd16;
  localparam logic [5:0] K_GREATER = 6'd18;
  localparam logic [5:0] K_SLASH   = 6'd20;
  localparam logic [5:0] K_IGNORED = 6'd21;
  localparam logic [5:0] K_TAB     = 6'd22;
  localparam logic [5:0] K_NEWLINE = 6'd23;
  localparam logic [5:0] K_STRING  = 6'd24;
  localparam logic [5:0] K_NUMBER  = 6'd25;
  localparam logic [5:0] K_IDENT   = 6'd26;
  localparam logic [5:0] K_KW0     = 6'd27;
  localparam logic [5:0] K_EOF     = 6'd38;
  localparam logic [5:0] K_ERROR   = 6'd39;

  // error codes
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_CHAR   = 2'd1;
  localparam logic [1:0] E_STRING = 2'd2;
  localparam logic [1:0] E_SAT    = 2'd3;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
    M_STRING, M_INT, M_DOTWAIT, M_FRAC, M_WORD
  } lex_mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] tok_start;
    logic [23:0] tok_len;
    logic [23:0] line_no;
    logic [7:0]  indent_level;
    logic [62:0] int_value;
    logic        has_fraction;
    logic [1:0]  error_code;
    logic        last;
  } tok_t;

  // keywords packed first byte lowest, zero padded
  localparam logic [63:0] KW_TEXT [11] = '{
    64'h65736c65, 64'h65736c6166, 64'h726f66, 64'h6669, 64'h6c6c756e,
    64'h746e697270, 64'h6e7275746572, 64'h7265707573, 64'h73696874,
    64'h65757274, 64'h656c696877
  };
  localparam logic [3:0] KW_LEN [11] = '{
    4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd5
  };

  function automatic logic [5:0] word_kind(input logic [63:0] pfx, input logic [3:0] wlen);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 10; i >= 0; i--) begin
      if (wlen == KW_LEN[i] && pfx == KW_TEXT[i]) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

endpackage

### src/source_lexer_tokenizer_unit.sv
// Streaming source scanner: one byte (or an end marker) is taken per cycle and
// tokens come out in order through a result queue of QUEUE_DEPTH beats. An item
// yields zero to three tokens, the final one marked last; the scanner classifies
// the byte in the cycle it is taken, so the input sustains one item per clock
// while full is low, and the result side drains one token per clock. full rises
// when fewer than three queue slots are free, which is the only input stall.
module source_lexer_tokenizer_unit import slt_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     empty,
  input  logic     pop,
  output tok_t     out_tok
);

  logic       take;
  logic [1:0] tok_cnt;
  tok_t       toks [3];

  assign take = push && !full;

  // front: byte classification
  slt_scan #(
    .POS_BITS(POS_BITS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_scan (
    .clk(clk),
    .rst_n(rst_n),
    .take(take),
    .item(in_item),
    .tok_cnt(tok_cnt),
    .toks(toks)
  );

  // back: result queue
  slt_outq u_outq (
    .clk(clk),
    .rst_n(rst_n),
    .wr_en(take),
    .wr_cnt(tok_cnt),
    .wr_toks(toks),
    .rd_en(pop),
    .rd_tok(out_tok),
    .q_empty(empty),
    .q_full(full)
  );

  // checks
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty) else $error("queue full while empty");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !take) |=> empty) else $error("beat appeared without an item");

  a_end_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_item.req_type == REQ_END) |=> !empty)
    else $error("end item gave no token");

endmodule

### src/slt_scan.sv
module slt_scan import slt_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic [1:0] tok_cnt,
  output tok_t     toks [3]
);

  localparam int PW  = 8 * KEYWORD_MAX_LEN;
  localparam int WLW = $clog2(KEYWORD_MAX_LEN + 2);

  lex_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt, beg_r, beg_nxt;
  logic [23:0]         line_r, line_nxt;
  logic [7:0]          tab_r, tab_nxt;
  logic [62:0]         acc_r, acc_nxt;
  logic                sat_r, sat_nxt;
  logic [PW-1:0]       pfx_r, pfx_nxt;
  logic [WLW-1:0]      wlen_r, wlen_nxt;

  function automatic logic [23:0] to24(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[23:0];
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      beg_r  <= '0;
      line_r <= 24'd1;
      tab_r  <= '0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
      pfx_r  <= '0;
      wlen_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      line_r <= line_nxt;
      tab_r  <= tab_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
      pfx_r  <= pfx_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  // per-byte scan: classify, emit up to three tokens
  always_comb begin
    logic [1:0]          n;
    logic                used;
    logic [7:0]          c;
    logic [POS_BITS-1:0] len, tb;
    logic [66:0]         sum;
    logic [5:0]          wk;
    logic [1:0]          nerr;
    n = 2'd0;
    used = 1'b1;
    c = item.ch;
    tb = beg_r;
    len = pos_r - beg_r;
    sum = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 67'(c - 8'h30);
    wk = word_kind(64'(pfx_r), 4'(wlen_r));
    nerr = sat_r ? E_SAT : E_NONE;
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    line_nxt = line_r;
    tab_nxt  = tab_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    pfx_nxt  = pfx_r;
    wlen_nxt = wlen_r;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '0;
      toks[i].line_no = line_r;
      toks[i].indent_level = tab_r;
    end

    if (item.req_type == REQ_END) begin
      // flush the pending token or tokens, then emit the end-of-file token
      case (mode_r)
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          toks[0].kind = (mode_r == M_BANG) ? K_BANG : (mode_r == M_EQUAL) ? K_EQUAL :
                         (mode_r == M_LESS) ? K_LESS : K_GREATER;
          toks[0].tok_start = to24(tb); toks[0].tok_len = 24'd1; n = 2'd1;
        end
        M_SLASH: begin
          toks[0].kind = K_SLASH; toks[0].tok_start = to24(tb);
          toks[0].tok_len = 24'd1; n = 2'd1;
        end
        M_COMMENT: begin
          toks[0].kind = K_IGNORED; toks[0].tok_start = to24(tb);
          toks[0].tok_len = to24(len); n = 2'd1;
        end
        M_STRING: begin
          toks[0].kind = K_ERROR; toks[0].tok_start = to24(tb);
          toks[0].tok_len = to24(len); toks[0].error_code = E_STRING; n = 2'd1;
        end
        M_INT, M_FRAC: begin
          toks[0].kind = K_NUMBER; toks[0].tok_start = to24(tb);
          toks[0].tok_len = to24(len); toks[0].int_value = acc_r;
          toks[0].has_fraction = (mode_r == M_FRAC); toks[0].error_code = nerr;
          n = 2'd1;
        end
        M_DOTWAIT: begin
          toks[0].kind = K_NUMBER; toks[0].tok_start = to24(tb);
          toks[0].tok_len = to24(len - 1'b1); toks[0].int_value = acc_r;
          toks[0].error_code = nerr;
          tb = pos_r - 1'b1;
          toks[1].kind = K_DOT; toks[1].tok_start = to24(tb); toks[1].tok_len = 24'd1;
          n = 2'd2;
        end
        M_WORD: begin
          toks[0].kind = wk; toks[0].tok_start = to24(tb);
          toks[0].tok_len = to24(len); n = 2'd1;
        end
        default: ;
      endcase
      toks[n].kind = K_EOF;
      toks[n].tok_start = to24(tb);
      toks[n].indent_level = 8'd0;
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      beg_nxt  = '0;
      line_nxt = 24'd1;
      tab_nxt  = '0;
      acc_nxt  = '0;
      sat_nxt  = 1'b0;
      pfx_nxt  = '0;
      wlen_nxt = '0;
    end else begin
      // continue the open lexeme
      case (mode_r)
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          toks[0].kind = (mode_r == M_BANG) ? K_BANG : (mode_r == M_EQUAL) ? K_EQUAL :
                         (mode_r == M_LESS) ? K_LESS : K_GREATER;
          toks[0].tok_start = to24(tb);
          if (c == "=") begin
            toks[0].kind = toks[0].kind + 6'd1;
            toks[0].tok_len = 24'd2;
          end else begin
            toks[0].tok_len = 24'd1;
            used = 1'b0;
          end
          n = 2'd1;
          mode_nxt = M_IDLE;
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_COMMENT;
          else begin
            toks[0].kind = K_SLASH; toks[0].tok_start = to24(tb);
            toks[0].tok_len = 24'd1; n = 2'd1;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) begin
            toks[0].kind = K_IGNORED; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len); n = 2'd1;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            toks[0].kind = K_STRING; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len + 1'b1); n = 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == 8'h0A && line_r != LINE_MAX) begin
            line_nxt = line_r + 24'd1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            if (sum > 67'(VAL_MAX)) begin
              acc_nxt = VAL_MAX; sat_nxt = 1'b1;
            end else acc_nxt = sum[62:0];
          end else if (c == ".") mode_nxt = M_DOTWAIT;
          else begin
            toks[0].kind = K_NUMBER; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len); toks[0].int_value = acc_r;
            toks[0].error_code = nerr; n = 2'd1;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_DOTWAIT: begin
          if (is_digit(c)) mode_nxt = M_FRAC;
          else begin
            toks[0].kind = K_NUMBER; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len - 1'b1); toks[0].int_value = acc_r;
            toks[0].error_code = nerr;
            tb = pos_r - 1'b1;
            toks[1].kind = K_DOT; toks[1].tok_start = to24(tb); toks[1].tok_len = 24'd1;
            n = 2'd2;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_FRAC: begin
          if (!is_digit(c)) begin
            toks[0].kind = K_NUMBER; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len); toks[0].int_value = acc_r;
            toks[0].has_fraction = 1'b1; toks[0].error_code = nerr; n = 2'd1;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (32'(wlen_r) < KEYWORD_MAX_LEN)
              pfx_nxt = pfx_r | (PW'(c) << {wlen_r, 3'b000});
            if (32'(wlen_r) <= KEYWORD_MAX_LEN) wlen_nxt = wlen_r + 1'b1;
          end else begin
            toks[0].kind = wk; toks[0].tok_start = to24(tb);
            toks[0].tok_len = to24(len); n = 2'd1;
            mode_nxt = M_IDLE; used = 1'b0;
          end
        end
        default: used = 1'b0;
      endcase

      // start a new lexeme on this byte
      if (!used) begin
        tb = pos_r;
        mode_nxt = M_IDLE;
        toks[n].tok_start = to24(pos_r);
        toks[n].tok_len = 24'd1;
        case (c)
          "(": begin toks[n].kind = 6'd0;  n = n + 2'd1; end
          ")": begin toks[n].kind = 6'd1;  n = n + 2'd1; end
          "{": begin toks[n].kind = 6'd2;  n = n + 2'd1; end
          "}": begin toks[n].kind = 6'd3;  n = n + 2'd1; end
          ",": begin toks[n].kind = 6'd4;  n = n + 2'd1; end
          ".": begin toks[n].kind = K_DOT; n = n + 2'd1; end
          "-": begin toks[n].kind = 6'd6;  n = n + 2'd1; end
          "+": begin toks[n].kind = 6'd7;  n = n + 2'd1; end
          ":": begin toks[n].kind = 6'd8;  n = n + 2'd1; end
          ";": begin toks[n].kind = 6'd9;  n = n + 2'd1; end
          "*": begin toks[n].kind = 6'd10; n = n + 2'd1; end
          "#": begin toks[n].kind = 6'd11; n = n + 2'd1; end
          "!": mode_nxt = M_BANG;
          "=": mode_nxt = M_EQUAL;
          "<": mode_nxt = M_LESS;
          ">": mode_nxt = M_GREATER;
          "/": mode_nxt = M_SLASH;
          " ", 8'h0D: begin toks[n].kind = K_IGNORED; n = n + 2'd1; end
          8'h09: begin
            toks[n].kind = K_TAB; n = n + 2'd1;
            if (tab_r != 8'hFF) tab_nxt = tab_r + 8'd1;
          end
          8'h0A: begin
            toks[n].kind = K_NEWLINE; n = n + 2'd1;
            tab_nxt = '0;
            if (line_r != LINE_MAX) line_nxt = line_r + 24'd1;
          end
          8'h22: mode_nxt = M_STRING;
          default: begin
            if (is_digit(c)) begin
              acc_nxt = 63'(c - 8'h30); sat_nxt = 1'b0; mode_nxt = M_INT;
            end else if (is_alpha(c)) begin
              pfx_nxt = PW'(c); wlen_nxt = WLW'(1); mode_nxt = M_WORD;
            end else begin
              toks[n].kind = K_ERROR; toks[n].error_code = E_CHAR; n = n + 2'd1;
            end
          end
        endcase
      end
      beg_nxt = tb;
      pos_nxt = pos_r + 1'b1;
    end

    if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
    tok_cnt = n;
  end

endmodule

### src/slt_outq.sv
module slt_outq import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_cnt,
  input  tok_t       wr_toks [3],
  input  logic       rd_en,
  output tok_t       rd_tok,
  output logic       q_empty,
  output logic       q_full
);

  tok_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic [1:0]          add;
  logic                sub;

  assign add = wr_en ? wr_cnt : 2'd0;
  assign sub = rd_en && !q_empty;

  // storage: up to three beats in per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < add) mem[wp_r + QUEUE_AW'(i)] <= wr_toks[i];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QUEUE_AW'(add);
      rp_r  <= rp_r + QUEUE_AW'(sub);
      cnt_r <= cnt_r + (QUEUE_AW+1)'(add) - (QUEUE_AW+1)'(sub);
    end
  end

  assign rd_tok  = mem[rp_r];
  assign q_empty = (cnt_r == '0);
  // room for a worst-case item of three beats
  assign q_full  = (cnt_r > (QUEUE_AW+1)'(QUEUE_DEPTH - 3));

endmodule
